// ===== src/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the overlapped pixel peak store.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int LIMIT_W     = 18;
  localparam int FRAME_W     = 8;
  localparam int PIX_INDEX_W = 19;

  localparam int PPF_W  = 20;
  localparam int HALF_W = 8;
  localparam logic [PPF_W-1:0]  PPF_RESET  = 20'd327680;
  localparam logic [HALF_W-1:0] HALF_RESET = 8'd15;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  // output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  // one stored entry of a bank
  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [FRAME_W-1:0]  frame;
  } entry_t;

  // one result transaction
  typedef struct packed {
    logic [SAMPLE_W-1:0]    peak_value;
    logic [FRAME_W-1:0]     peak_frame;
    logic                   above_background;
    logic [PIX_INDEX_W-1:0] pixel_index;
    logic                   last_pixel;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/pps_out_fifo.sv =====
// ----------------------------------------------------------------------------
// pps_out_fifo
// Small result queue that decouples the store pipeline from the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_out_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  input  wire pps_pkg::out_item_t            push_item,
  input  wire logic                          pop_ready,
  output logic                               pop_valid,
  output pps_pkg::out_item_t                 pop_item,
  output logic [pps_pkg::FIFO_CNT_W-1:0]     count
);

  pps_pkg::out_item_t                 slot_r [pps_pkg::FIFO_DEPTH];
  logic [pps_pkg::FIFO_PTR_W-1:0]     head_r, head_nxt;
  logic [pps_pkg::FIFO_PTR_W-1:0]     tail_r, tail_nxt;
  logic [pps_pkg::FIFO_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                               pop;

  assign pop_valid = (cnt_r != '0);
  assign pop_item  = slot_r[head_r];
  assign pop       = pop_valid && pop_ready;
  assign count     = cnt_r;

  always_comb begin
    head_nxt = pop ? head_r + 1'b1 : head_r;
    tail_nxt = push ? tail_r + 1'b1 : tail_r;
    cnt_nxt  = cnt_r + pps_pkg::FIFO_CNT_W'(push) - pps_pkg::FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[tail_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== src/pixel_peak_store_overlapped_core.sv =====
// ----------------------------------------------------------------------------
// pixel_peak_store_overlapped_core
// Temporal peak hold per pixel over half-overlapping windows of frames.
// ----------------------------------------------------------------------------
// Pixels enter on the in_ stream in raster order, one frame after another,
// each with its background limit. Frames form half windows of half_window
// frames; a window is two consecutive half windows. On each pixel of a
// window's last frame one transaction leaves on the out_ stream with the
// pixel's peak, the window offset of its first occurrence, the background
// flag (tuser) and the frame's last pixel (tlast); other pixels give none.
// The per-pixel state sits in two single-port-read memories, one per
// half-window parity; each pixel reads both at the current raster index and
// writes them back in the next cycle (only the running one until a half
// window has completed), with a bypass for back-to-back hits on the same
// entry (one-pixel frames). A result is registered in the update stage, then
// written into the result queue, which presents it on out_. Throughput: one
// pixel per cycle while in_tready is high, set by the read-modify-write loop
// on the memories, which overlaps one pixel's write with the next pixel's
// read. The receiver may stall: a four-entry result queue absorbs results,
// and in_tready drops while queue plus the pixel in flight would fill it.
// Reset clears the counters and the queue; store contents are not cleared,
// and each bank is loaded on the first frame of the half window it serves.
// Registers sit on an APB port: pixels_per_frame at 0x0, half_window at 0x4.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_peak_store_overlapped_core #(
  parameter int MAX_PIXELS      = 524288,
  parameter int MAX_HALF_WINDOW = 128
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic [2:0]                           cfg_paddr,
  input  wire logic [31:0]                          cfg_pwdata,
  output logic [31:0]                               cfg_prdata,
  output logic                                      cfg_pready,
  // pixel stream
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // [15:0] sample, [33:16] background_limit
  input  wire logic [pps_pkg::IN_TDATA_W-1:0]       in_tdata,
  // result stream
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // [15:0] peak_value, [23:16] peak_frame, [42:24] pixel_index
  output logic [pps_pkg::OUT_TDATA_W-1:0]           out_tdata,
  // [0] above_background
  output logic [0:0]                                out_tuser,
  output logic                                      out_tlast
);

  localparam int PIX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int FIH_W = (MAX_HALF_WINDOW > 1) ? $clog2(MAX_HALF_WINDOW) : 1;
  localparam int PCW   = ($clog2(MAX_PIXELS + 1) > pps_pkg::PPF_W) ?
                         $clog2(MAX_PIXELS + 1) : pps_pkg::PPF_W;
  localparam int HCW   = ($clog2(MAX_HALF_WINDOW + 1) > pps_pkg::HALF_W) ?
                         $clog2(MAX_HALF_WINDOW + 1) : pps_pkg::HALF_W;

  typedef enum logic {
    REG_PIXELS_PER_FRAME = 1'b0,
    REG_HALF_WINDOW      = 1'b1
  } reg_sel_t;

  // configuration registers
  logic [pps_pkg::PPF_W-1:0]  ppf_r;
  logic [pps_pkg::HALF_W-1:0] hw_r;
  reg_sel_t                   reg_sel;
  logic                       cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_sel    = reg_sel_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (reg_sel)
      REG_PIXELS_PER_FRAME: cfg_prdata = 32'(ppf_r);
      REG_HALF_WINDOW:      cfg_prdata = 32'(hw_r);
      default:              cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppf_r <= pps_pkg::PPF_RESET;
      hw_r  <= pps_pkg::HALF_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_PIXELS_PER_FRAME: ppf_r <= cfg_pwdata[pps_pkg::PPF_W-1:0];
        REG_HALF_WINDOW:      hw_r  <= cfg_pwdata[pps_pkg::HALF_W-1:0];
        default:              ;
      endcase
    end
  end

  // effective register values, clamped to the supported range
  logic [PCW-1:0] ppf_ext, ppf_eff;
  logic [HCW-1:0] hw_ext, hw_eff;

  always_comb begin
    ppf_ext = PCW'(ppf_r);
    if (ppf_ext == '0) begin
      ppf_eff = PCW'(1);
    end else if (ppf_ext > PCW'(MAX_PIXELS)) begin
      ppf_eff = PCW'(MAX_PIXELS);
    end else begin
      ppf_eff = ppf_ext;
    end
    hw_ext = HCW'(hw_r);
    if (hw_ext == '0) begin
      hw_eff = HCW'(1);
    end else if (hw_ext > HCW'(MAX_HALF_WINDOW)) begin
      hw_eff = HCW'(MAX_HALF_WINDOW);
    end else begin
      hw_eff = hw_ext;
    end
  end

  // position counters
  logic [PIX_W-1:0] pix_cnt_r, pix_cnt_nxt;
  logic [FIH_W-1:0] fih_r, fih_nxt;
  logic             parity_r, parity_nxt;
  logic             second_r, second_nxt;
  logic             last_pix, last_frame;
  logic             in_accept;

  logic [pps_pkg::FIFO_CNT_W-1:0] fifo_cnt;
  logic                           s1_valid_r;

  assign in_tready  = (fifo_cnt + pps_pkg::FIFO_CNT_W'(s1_valid_r)) <
                      pps_pkg::FIFO_CNT_W'(pps_pkg::FIFO_DEPTH);
  assign in_accept  = in_tvalid && in_tready;
  assign last_pix   = (PCW'(pix_cnt_r) + PCW'(1)) >= ppf_eff;
  assign last_frame = (HCW'(fih_r) + HCW'(1)) >= hw_eff;

  always_comb begin
    pix_cnt_nxt = pix_cnt_r;
    fih_nxt     = fih_r;
    parity_nxt  = parity_r;
    second_nxt  = second_r;
    if (in_accept) begin
      if (last_pix) begin
        pix_cnt_nxt = '0;
        if (last_frame) begin
          fih_nxt    = '0;
          parity_nxt = !parity_r;
          second_nxt = 1'b1;
        end else begin
          fih_nxt = fih_r + 1'b1;
        end
      end else begin
        pix_cnt_nxt = pix_cnt_r + 1'b1;
      end
    end
  end

  // stage 1: memory read data arrives, entries are updated and written back
  logic [pps_pkg::SAMPLE_W-1:0] s1_sample_r;
  logic [pps_pkg::LIMIT_W-1:0]  s1_limit_r;
  logic [PIX_W-1:0]             s1_pix_r;
  logic                         s1_first_r;
  logic [pps_pkg::FRAME_W-1:0]  s1_cur_off_r;
  logic [pps_pkg::FRAME_W-1:0]  s1_old_off_r;
  logic                         s1_second_r;
  logic                         s1_last_frame_r;
  logic                         s1_last_pix_r;
  logic                         s1_parity_r;

  pps_pkg::entry_t bank0_mem [MAX_PIXELS];
  pps_pkg::entry_t bank1_mem [MAX_PIXELS];
  pps_pkg::entry_t bank0_rd_r, bank1_rd_r;
  pps_pkg::entry_t fwd0_data_r, fwd1_data_r;
  logic            fwd0_hit_r, fwd1_hit_r;
  pps_pkg::entry_t bank0_q, bank1_q;
  pps_pkg::entry_t cur_q, old_q, cur_new, old_new;
  pps_pkg::entry_t wdata0, wdata1;
  logic            we0, we1;
  logic            emit;
  pps_pkg::out_item_t res_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_cnt_r  <= '0;
      fih_r      <= '0;
      parity_r   <= 1'b0;
      second_r   <= 1'b0;
      s1_valid_r <= 1'b0;
      fwd0_hit_r <= 1'b0;
      fwd1_hit_r <= 1'b0;
    end else begin
      pix_cnt_r  <= pix_cnt_nxt;
      fih_r      <= fih_nxt;
      parity_r   <= parity_nxt;
      second_r   <= second_nxt;
      s1_valid_r <= in_accept;
      // a write-back landing on the entry being read this same edge
      if (in_accept) begin
        fwd0_hit_r <= we0 && (s1_pix_r == pix_cnt_r);
        fwd1_hit_r <= we1 && (s1_pix_r == pix_cnt_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample_r     <= in_tdata[15:0];
      s1_limit_r      <= in_tdata[33:16];
      s1_pix_r        <= pix_cnt_r;
      s1_first_r      <= (fih_r == '0);
      s1_cur_off_r    <= pps_pkg::FRAME_W'(fih_r);
      s1_old_off_r    <= pps_pkg::FRAME_W'(hw_eff + HCW'(fih_r));
      s1_second_r     <= second_r;
      s1_last_frame_r <= last_frame;
      s1_last_pix_r   <= last_pix;
      s1_parity_r     <= parity_r;
      fwd0_data_r     <= wdata0;
      fwd1_data_r     <= wdata1;
    end
  end

  always_ff @(posedge clk) begin
    if (we0) begin
      bank0_mem[s1_pix_r] <= wdata0;
    end
    if (in_accept) begin
      bank0_rd_r <= bank0_mem[pix_cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      bank1_mem[s1_pix_r] <= wdata1;
    end
    if (in_accept) begin
      bank1_rd_r <= bank1_mem[pix_cnt_r];
    end
  end

  always_comb begin
    bank0_q = fwd0_hit_r ? fwd0_data_r : bank0_rd_r;
    bank1_q = fwd1_hit_r ? fwd1_data_r : bank1_rd_r;
    cur_q   = s1_parity_r ? bank1_q : bank0_q;
    old_q   = s1_parity_r ? bank0_q : bank1_q;

    // bank of the running half window: loaded on its first frame
    if (s1_first_r) begin
      cur_new.value = s1_sample_r;
      cur_new.frame = '0;
    end else if (s1_sample_r > cur_q.value) begin
      cur_new.value = s1_sample_r;
      cur_new.frame = s1_cur_off_r;
    end else begin
      cur_new = cur_q;
    end

    // bank of the window that started one half earlier
    if (s1_sample_r > old_q.value) begin
      old_new.value = s1_sample_r;
      old_new.frame = s1_old_off_r;
    end else begin
      old_new = old_q;
    end

    wdata0 = s1_parity_r ? old_new : cur_new;
    wdata1 = s1_parity_r ? cur_new : old_new;
    we0    = s1_valid_r && (!s1_parity_r || s1_second_r);
    we1    = s1_valid_r && (s1_parity_r || s1_second_r);
    emit   = s1_valid_r && s1_second_r && s1_last_frame_r;

    res_item.peak_value       = old_new.value;
    res_item.peak_frame       = old_new.frame;
    res_item.above_background = pps_pkg::LIMIT_W'(old_new.value) > s1_limit_r;
    res_item.pixel_index      = pps_pkg::PIX_INDEX_W'(s1_pix_r);
    res_item.last_pixel       = s1_last_pix_r;
  end

  pps_pkg::out_item_t out_item;

  pps_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit),
    .push_item (res_item),
    .pop_ready (out_tready),
    .pop_valid (out_tvalid),
    .pop_item  (out_item),
    .count     (fifo_cnt)
  );

  assign out_tdata = {5'd0, out_item.pixel_index, out_item.peak_frame, out_item.peak_value};
  assign out_tuser = out_item.above_background;
  assign out_tlast = out_item.last_pixel;

`ifndef SYNTHESIS
  // a result must always find room in the queue
  a_no_queue_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (fifo_cnt < pps_pkg::FIFO_CNT_W'(pps_pkg::FIFO_DEPTH)))
    else $error("result queue overflow");

  // the update stage only ever holds a pixel accepted in the previous cycle
  a_stage_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> $past(in_accept))
    else $error("update stage valid without accepted pixel");

  // banks swap roles at the end of every half window
  a_parity_swaps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && last_pix && last_frame) |=> (parity_r != $past(parity_r)))
    else $error("bank parity did not swap at end of half window");

  // no output transaction before a full half window has completed
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    !second_r |-> !emit)
    else $error("result emitted before first half window completed");
`endif

endmodule

`default_nettype wire
